// File: hdl/rabc_pkg.sv
package rabc_pkg;

   // fixed-point layout of the term values
   localparam int FRACTION_BITS = 16;

   // default number of entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] VERDICT_KEEP       = 2'd0;
   localparam logic [1:0] VERDICT_REDUNDANT  = 2'd1;
   localparam logic [1:0] VERDICT_INFEASIBLE = 2'd2;

   typedef struct packed {
      logic signed [31:0] coefficient;
      logic signed [31:0] var_low;
      logic               var_low_infinite;
      logic signed [31:0] var_high;
      logic               var_high_infinite;
      logic signed [31:0] row_low;
      logic               row_low_infinite;
      logic signed [31:0] row_high;
      logic               row_high_infinite;
      logic               last_term;
   } rabc_req_type;

   typedef struct packed {
      logic signed [63:0] least_activity;
      logic               min_unbounded;
      logic signed [63:0] greatest_activity;
      logic               max_unbounded;
      logic [1:0]         verdict;
   } rabc_rsp_type;

   // one classified term, products formed, waiting for the accumulators
   typedef struct packed {
      logic signed [63:0] min_product;
      logic               min_infinite;
      logic signed [63:0] max_product;
      logic               max_infinite;
      logic signed [31:0] row_low;
      logic               row_low_infinite;
      logic signed [31:0] row_high;
      logic               row_high_infinite;
      logic               last_term;
   } rabc_term_type;

   // finished row activities, waiting for the verdict
   typedef struct packed {
      logic signed [63:0] least_activity;
      logic               min_unbounded;
      logic signed [63:0] greatest_activity;
      logic               max_unbounded;
      logic signed [31:0] row_low;
      logic               row_low_infinite;
      logic signed [31:0] row_high;
      logic               row_high_infinite;
   } rabc_row_type;

endpackage

// File: hdl/rabc_req_if.sv
interface rabc_req_if;
   import rabc_pkg::*;

   logic         valid;
   logic         ready;
   rabc_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rabc_rsp_if.sv
interface rabc_rsp_if;
   import rabc_pkg::*;

   logic         valid;
   logic         ready;
   rabc_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/row_activity_bound_checker.sv
// channel   direction  handshake          payload
// req_if    in         valid / ready      one row term: coefficient, variable and row bounds
// rsp_if    out        valid / ready      row activities and verdict, one per last term
// csr       in         csr_write_en       tolerance, 16 bits, written while idle
//
// one term per cycle sustained while the result side does not stall; a result passes the
// classify, multiply, queue, accumulate and verdict registers after its last term is taken
// the accumulator add with saturation is the one loop that sets the rate
// reset is synchronous; it empties the pipeline and queue, clears the row sums and
// sets the tolerance to 1
// req_ready drops only when the queue, counting terms still in the front stages, is full;
// the output register and the row snapshot let the next row accumulate while a result waits
module row_activity_bound_checker #(
   parameter int QUEUE_DEPTH = rabc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   rabc_req_if.sink    req_if,
   rabc_rsp_if.source  rsp_if,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);
   import rabc_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // comparison slack, Q16.16 units
   logic [15:0]      tolerance_ff;

   // front to queue
   logic             push;
   rabc_term_type    push_term;

   // queue to back
   rabc_term_type    head_term;
   logic             queue_empty;
   logic             pop;
   logic [CNT_W-1:0] queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= 16'd1;
      end else if (csr_write_en) begin
         tolerance_ff <= csr_write_data;
      end
   end

   // front: takes terms, picks the bound that counts on each side, forms both products
   rabc_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .tolerance   (tolerance_ff),
      .queue_count (queue_count),
      .push        (push),
      .push_term   (push_term)
   );

   // short queue that decouples the front from the accumulators
   rabc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_term (push_term),
      .pop       (pop),
      .head_term (head_term),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   // back: saturating sums, row close, verdict and output register
   rabc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_term (head_term),
      .empty     (queue_empty),
      .pop       (pop),
      .tolerance (tolerance_ff),
      .rsp_if    (rsp_if)
   );

endmodule

// File: hdl/rabc_front.sv
module rabc_front #(
   parameter int QUEUE_DEPTH = rabc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   rabc_req_if.sink                         req_if,
   input  logic [15:0]                      tolerance,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                             push,
   output rabc_pkg::rabc_term_type          push_term
);
   import rabc_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // classify stage
   logic               s1_valid_ff, s1_valid_in;
   logic signed [31:0] s1_coef_ff, s1_coef_in;
   logic signed [31:0] s1_min_b_ff, s1_min_b_in;
   logic signed [31:0] s1_max_b_ff, s1_max_b_in;
   logic               s1_min_inf_ff, s1_min_inf_in;
   logic               s1_max_inf_ff, s1_max_inf_in;
   rabc_req_type       s1_req_ff;

   // product stage
   logic               s2_valid_ff;
   rabc_term_type      s2_term_ff, s2_term_in;

   logic [32:0]        magnitude;
   logic               significant;
   logic               positive;
   logic [CNT_W+1:0]   occupancy;
   logic               accept;

   // credit: every item in flight already owns a queue slot
   assign occupancy = (CNT_W+2)'(queue_count) + (CNT_W+2)'(s1_valid_ff)
                      + (CNT_W+2)'(s2_valid_ff);
   assign req_if.ready = occupancy < (CNT_W+2)'(QUEUE_DEPTH);
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      magnitude = req_if.data.coefficient[31] ? (33'd0 - 33'(req_if.data.coefficient))
                                              : 33'(req_if.data.coefficient);
      significant = magnitude > 33'(tolerance);
      positive = !req_if.data.coefficient[31];
      s1_valid_in = accept;
      s1_coef_in = req_if.data.coefficient;
      s1_min_inf_in = significant && (positive ? req_if.data.var_low_infinite
                                               : req_if.data.var_high_infinite);
      s1_max_inf_in = significant && (positive ? req_if.data.var_high_infinite
                                               : req_if.data.var_low_infinite);
      // negligible or unbounded side contributes a zero product
      s1_min_b_in = '0;
      if (significant && !s1_min_inf_in) begin
         s1_min_b_in = positive ? req_if.data.var_low : req_if.data.var_high;
      end
      s1_max_b_in = '0;
      if (significant && !s1_max_inf_in) begin
         s1_max_b_in = positive ? req_if.data.var_high : req_if.data.var_low;
      end
   end

   always_comb begin
      s2_term_in.min_product       = 64'(s1_coef_ff) * 64'(s1_min_b_ff);
      s2_term_in.max_product       = 64'(s1_coef_ff) * 64'(s1_max_b_ff);
      s2_term_in.min_infinite      = s1_min_inf_ff;
      s2_term_in.max_infinite      = s1_max_inf_ff;
      s2_term_in.row_low           = s1_req_ff.row_low;
      s2_term_in.row_low_infinite  = s1_req_ff.row_low_infinite;
      s2_term_in.row_high          = s1_req_ff.row_high;
      s2_term_in.row_high_infinite = s1_req_ff.row_high_infinite;
      s2_term_in.last_term         = s1_req_ff.last_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      if (accept) begin
         s1_coef_ff    <= s1_coef_in;
         s1_min_b_ff   <= s1_min_b_in;
         s1_max_b_ff   <= s1_max_b_in;
         s1_min_inf_ff <= s1_min_inf_in;
         s1_max_inf_ff <= s1_max_inf_in;
         s1_req_ff     <= req_if.data;
      end
      if (s1_valid_ff) begin
         s2_term_ff <= s2_term_in;
      end
   end

   assign push      = s2_valid_ff;
   assign push_term = s2_term_ff;

endmodule

// File: hdl/rabc_queue.sv
module rabc_queue #(
   parameter int QUEUE_DEPTH = rabc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  rabc_pkg::rabc_term_type          push_term,
   input  logic                             pop,
   output rabc_pkg::rabc_term_type          head_term,
   output logic                             empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
   import rabc_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   rabc_term_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_term;
      end
   end

   assign head_term = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

endmodule

// File: hdl/rabc_back.sv
module rabc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rabc_pkg::rabc_term_type head_term,
   input  logic                    empty,
   output logic                    pop,
   input  logic [15:0]             tolerance,
   rabc_rsp_if.source              rsp_if
);
   import rabc_pkg::*;

   logic signed [63:0] min_sum_ff, min_sum_in;
   logic signed [63:0] max_sum_ff, max_sum_in;
   logic               min_unb_ff, min_unb_in;
   logic               max_unb_ff, max_unb_in;

   logic               snap_valid_ff, snap_valid_in;
   rabc_row_type       snap_ff, snap_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rabc_rsp_type       rsp_data_ff, rsp_data_in;

   logic               snap_move;
   logic               snap_free;

   logic signed [65:0] lo_w, hi_w, eps_w, hi_pe, lo_me, min_w, max_w;
   logic               infeasible, lower_ok, upper_ok;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   assign snap_move = snap_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign snap_free = !snap_valid_ff || snap_move;
   assign pop       = !empty && (!head_term.last_term || snap_free);

   // accumulate one term, close the row on its last term
   always_comb begin
      min_unb_in = min_unb_ff || head_term.min_infinite;
      max_unb_in = max_unb_ff || head_term.max_infinite;
      min_sum_in = min_unb_in ? min_sum_ff : sat_add(min_sum_ff, head_term.min_product);
      max_sum_in = max_unb_in ? max_sum_ff : sat_add(max_sum_ff, head_term.max_product);

      snap_in.least_activity    = min_unb_in ? '0 : min_sum_in;
      snap_in.min_unbounded     = min_unb_in;
      snap_in.greatest_activity = max_unb_in ? '0 : max_sum_in;
      snap_in.max_unbounded     = max_unb_in;
      snap_in.row_low           = head_term.row_low;
      snap_in.row_low_infinite  = head_term.row_low_infinite;
      snap_in.row_high          = head_term.row_high;
      snap_in.row_high_infinite = head_term.row_high_infinite;

      snap_valid_in = snap_valid_ff;
      if (snap_move) begin
         snap_valid_in = 1'b0;
      end
      if (pop && head_term.last_term) begin
         snap_valid_in = 1'b1;
      end
   end

   // verdict from the finished row
   always_comb begin
      lo_w  = 66'(snap_ff.row_low) <<< FRACTION_BITS;
      hi_w  = 66'(snap_ff.row_high) <<< FRACTION_BITS;
      eps_w = 66'(tolerance) << FRACTION_BITS;
      hi_pe = hi_w + eps_w;
      lo_me = lo_w - eps_w;
      min_w = 66'(snap_ff.least_activity);
      max_w = 66'(snap_ff.greatest_activity);

      infeasible = (!snap_ff.row_low_infinite && !snap_ff.row_high_infinite && lo_w > hi_pe)
                   || (!snap_ff.min_unbounded && !snap_ff.row_high_infinite && min_w > hi_pe)
                   || (!snap_ff.max_unbounded && !snap_ff.row_low_infinite && max_w < lo_me);
      lower_ok = snap_ff.row_low_infinite || (!snap_ff.min_unbounded && min_w >= lo_me);
      upper_ok = snap_ff.row_high_infinite || (!snap_ff.max_unbounded && max_w <= hi_pe);

      rsp_data_in.least_activity    = snap_ff.least_activity;
      rsp_data_in.min_unbounded     = snap_ff.min_unbounded;
      rsp_data_in.greatest_activity = snap_ff.greatest_activity;
      rsp_data_in.max_unbounded     = snap_ff.max_unbounded;
      if (infeasible) begin
         rsp_data_in.verdict = VERDICT_INFEASIBLE;
      end else if (lower_ok && upper_ok) begin
         rsp_data_in.verdict = VERDICT_REDUNDANT;
      end else begin
         rsp_data_in.verdict = VERDICT_KEEP;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (snap_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sum_ff    <= '0;
         max_sum_ff    <= '0;
         min_unb_ff    <= 1'b0;
         max_unb_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            if (head_term.last_term) begin
               min_sum_ff <= '0;
               max_sum_ff <= '0;
               min_unb_ff <= 1'b0;
               max_unb_ff <= 1'b0;
            end else begin
               min_sum_ff <= min_sum_in;
               max_sum_ff <= max_sum_in;
               min_unb_ff <= min_unb_in;
               max_unb_ff <= max_unb_in;
            end
         end
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (pop && head_term.last_term) begin
         snap_ff <= snap_in;
      end
      if (snap_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

// File: dv/row_verdict_checker.sv
`timescale 1ns / 100ps

module row_verdict_checker
   import rabc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  rabc_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rabc_rsp_type rsp_data,
   input  logic         csr_write_en,
   input  logic [15:0]  csr_write_data,
   output int           mismatch_count,
   output int           rows_in_flight
);

   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
   // Q16.16 to Q32.32
   localparam longint Q32_SCALE = longint'(1) << FRACTION_BITS;

   logic [15:0]  tolerance;
   longint       min_sum;
   longint       max_sum;
   bit           min_unbounded;
   bit           max_unbounded;
   rabc_rsp_type awaited_rows[$];

   function automatic longint add_saturated(input longint a, input longint b);
      if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
      if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
      return a + b;
   endfunction

   // folds one term into the open row; on the last term fills the row result
   function automatic bit absorb_term(input rabc_req_type t, output rabc_rsp_type row);
      longint coef;
      longint mag;
      longint min_bound;
      longint max_bound;
      longint eps;
      longint lo;
      longint hi;
      bit     min_inf;
      bit     max_inf;
      bit     infeasible;
      bit     lower_ok;
      bit     upper_ok;
      coef = longint'(t.coefficient);
      mag  = coef < 0 ? -coef : coef;
      row  = '0;
      if (mag > longint'(tolerance)) begin
         min_bound = coef > 0 ? longint'(t.var_low) : longint'(t.var_high);
         min_inf   = coef > 0 ? t.var_low_infinite : t.var_high_infinite;
         max_bound = coef > 0 ? longint'(t.var_high) : longint'(t.var_low);
         max_inf   = coef > 0 ? t.var_high_infinite : t.var_low_infinite;
         if (min_inf) min_unbounded = 1'b1;
         else if (!min_unbounded) min_sum = add_saturated(min_sum, coef * min_bound);
         if (max_inf) max_unbounded = 1'b1;
         else if (!max_unbounded) max_sum = add_saturated(max_sum, coef * max_bound);
      end
      if (!t.last_term) return 1'b0;

      eps = longint'(tolerance) * Q32_SCALE;
      lo  = longint'(t.row_low) * Q32_SCALE;
      hi  = longint'(t.row_high) * Q32_SCALE;
      infeasible = (!t.row_low_infinite && !t.row_high_infinite && lo > hi + eps)
                || (!min_unbounded && !t.row_high_infinite && min_sum > hi + eps)
                || (!max_unbounded && !t.row_low_infinite && max_sum < lo - eps);
      lower_ok = t.row_low_infinite || (!min_unbounded && min_sum >= lo - eps);
      upper_ok = t.row_high_infinite || (!max_unbounded && max_sum <= hi + eps);

      row.least_activity    = min_unbounded ? 64'sd0 : min_sum;
      row.min_unbounded     = min_unbounded;
      row.greatest_activity = max_unbounded ? 64'sd0 : max_sum;
      row.max_unbounded     = max_unbounded;
      if (infeasible) row.verdict = VERDICT_INFEASIBLE;
      else if (lower_ok && upper_ok) row.verdict = VERDICT_REDUNDANT;
      else row.verdict = VERDICT_KEEP;

      min_sum       = 0;
      max_sum       = 0;
      min_unbounded = 1'b0;
      max_unbounded = 1'b0;
      return 1'b1;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] expected,
                              input logic signed [63:0] actual);
      if (actual !== expected) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", field, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      rabc_rsp_type row;
      rabc_rsp_type oldest;
      if (reset) begin
         tolerance      = 16'd1;
         min_sum        = 0;
         max_sum        = 0;
         min_unbounded  = 1'b0;
         max_unbounded  = 1'b0;
         mismatch_count = 0;
         awaited_rows.delete();
         rows_in_flight = 0;
      end else begin
         // results first: a result leaving now belongs to an earlier row
         if (rsp_valid && rsp_ready) begin
            if (awaited_rows.size() == 0) begin
               mismatch_count++;
               $error("result item with no row pending");
            end else begin
               oldest = awaited_rows.pop_front();
               check_field("least_activity", oldest.least_activity,
                           rsp_data.least_activity);
               check_field("min_unbounded", 64'(oldest.min_unbounded),
                           64'(rsp_data.min_unbounded));
               check_field("greatest_activity", oldest.greatest_activity,
                           rsp_data.greatest_activity);
               check_field("max_unbounded", 64'(oldest.max_unbounded),
                           64'(rsp_data.max_unbounded));
               check_field("verdict", 64'(oldest.verdict), 64'(rsp_data.verdict));
            end
         end
         if (req_valid && req_ready && absorb_term(req_data, row))
            awaited_rows.insert(awaited_rows.size(), row);
         if (csr_write_en)
            tolerance = csr_write_data;
         rows_in_flight = awaited_rows.size();
      end
   end

endmodule

// File: dv/tb_row_activity_bound_checker.sv
`timescale 1ns / 100ps

module tb_row_activity_bound_checker;
   import rabc_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   // margin for a row result to leave after its last term, so this covers trailing terms
   localparam int DRAIN_CYCLES = 12;
   localparam int TIMEOUT_NS   = 400_000 * CLOCK_PERIOD;
   localparam int PHASE_COUNT  = 7;
   localparam int PHASE_ITEMS  = 136;

   // q16.16 landmarks
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // infinity flags as {high, low}
   localparam bit [1:0] NO_INF   = 2'b00;
   localparam bit [1:0] LOW_INF  = 2'b01;
   localparam bit [1:0] HIGH_INF = 2'b10;
   localparam bit [1:0] BOTH_INF = 2'b11;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [15:0] csr_write_data;
   logic [15:0] tolerance_setting;
   bit          steady;   // no idling on either side while set
   int          mismatch_count;
   int          rows_in_flight;

   rabc_req_if req_if ();
   rabc_rsp_if rsp_if ();

   row_activity_bound_checker u_top (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // watches both channels and the tolerance port, predicts every row result
   row_verdict_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_data       (req_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_data       (rsp_if.data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .rows_in_flight (rows_in_flight)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

   // result side: stalls at random about ten percent of the time, never while steady
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = steady || ($urandom_range(99) >= 10);
      end
   end

   function automatic rabc_req_type term(
      input logic signed [31:0] coefficient,
      input logic signed [31:0] var_low,
      input logic signed [31:0] var_high,
      input bit [1:0]           var_inf,
      input logic signed [31:0] row_low,
      input logic signed [31:0] row_high,
      input bit [1:0]           row_inf,
      input bit                 last_term
   );
      rabc_req_type t;
      t.coefficient       = coefficient;
      t.var_low           = var_low;
      t.var_low_infinite  = var_inf[0];
      t.var_high          = var_high;
      t.var_high_infinite = var_inf[1];
      t.row_low           = row_low;
      t.row_low_infinite  = row_inf[0];
      t.row_high          = row_high;
      t.row_high_infinite = row_inf[1];
      t.last_term         = last_term;
      return t;
   endfunction

   // mostly small values so verdicts vary, plus extremes and full-width noise
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(19))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3, 4, 5: return $urandom;
         6, 7, 8: return $signed($urandom) >>> $urandom_range(24, 8);
         default: return (int'($urandom_range(16383)) - 8192) * 32;   // about +-4.0
      endcase
   endfunction

   // row bounds sized to land near typical activities
   function automatic logic signed [31:0] random_row_bound();
      if ($urandom_range(9) == 0) return $urandom;
      return (int'($urandom_range(4095)) - 2048) * 1024;   // about +-32.0
   endfunction

   function automatic logic signed [31:0] random_coefficient();
      int near;
      case ($urandom_range(9))
         0: begin
            // straddle the negligible-coefficient threshold
            near = int'(tolerance_setting) + int'($urandom_range(2)) - 1;
            if (near < 0) near = 0;
            return $urandom_range(1) ? near : -near;
         end
         1:       return '0;
         default: return random_value();
      endcase
   endfunction

   function automatic rabc_req_type random_term(input bit last_term);
      rabc_req_type       t;
      logic signed [31:0] a;
      logic signed [31:0] b;
      t.coefficient = random_coefficient();
      a = random_value();
      b = random_value();
      // mostly ordered boxes, sometimes inverted ones
      if ($urandom_range(4) != 0 && a > b) begin
         t.var_low  = b;
         t.var_high = a;
      end else begin
         t.var_low  = a;
         t.var_high = b;
      end
      t.var_low_infinite  = ($urandom_range(9) == 0);
      t.var_high_infinite = ($urandom_range(9) == 0);
      a = random_row_bound();
      b = random_row_bound();
      if ($urandom_range(4) != 0 && a > b) begin
         t.row_low  = b;
         t.row_high = a;
      end else begin
         t.row_low  = a;
         t.row_high = b;
      end
      t.row_low_infinite  = ($urandom_range(6) == 0);
      t.row_high_infinite = ($urandom_range(6) == 0);
      t.last_term         = last_term;
      return t;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_term(input rabc_req_type t);
      while (!steady && $urandom_range(99) < 10) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.data  = t;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // whole rows only, so a tolerance change never lands mid-row
   task automatic random_rows(input int item_budget);
      int sent;
      int length;
      sent = 0;
      while (sent < item_budget) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
         for (int k = 0; k < length; k++)
            send_term(random_term(k == length - 1));
         sent += length;
      end
   endtask

   // waits for the block to go idle before touching the register
   task automatic set_tolerance(input logic [15:0] value);
      req_if.valid = 1'b0;
      while (rows_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_en      = 1'b1;
      csr_write_data    = value;
      tolerance_setting = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   initial begin
      logic [15:0] value;
      reset             = 1'b1;
      steady            = 1'b0;
      csr_write_en      = 1'b0;
      csr_write_data    = '0;
      tolerance_setting = 16'd1;
      req_if.valid      = 1'b0;
      req_if.data       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows at the reset tolerance
      // plain bounded row inside its bounds
      send_term(term(ONE, -2 * ONE, 3 * ONE, NO_INF, -10 * ONE, 10 * ONE, NO_INF, 1));
      // negative coefficient takes the infinite lower bound into the max side
      send_term(term(-ONE, '0, 4 * ONE, LOW_INF, -10 * ONE, 10 * ONE, NO_INF, 1));
      // only negligible coefficients: empty row
      send_term(term(32'sd1, '0, '0, BOTH_INF, '0, '0, NO_INF, 0));
      send_term(term(-32'sd1, '0, '0, BOTH_INF, '0, '0, NO_INF, 0));
      send_term(term('0, Q_MAX, Q_MIN, NO_INF, '0, '0, NO_INF, 1));
      // crossed row bounds
      send_term(term(ONE, ONE, 2 * ONE, NO_INF, 5 * ONE, 3 * ONE, NO_INF, 1));
      // least activity above the row upper bound
      send_term(term(ONE, 10 * ONE, 20 * ONE, NO_INF, '0, 5 * ONE, LOW_INF, 1));
      // greatest activity below the row lower bound
      send_term(term(2 * ONE, -20 * ONE, -10 * ONE, NO_INF, '0, '0, HIGH_INF, 1));
      // both sums saturate high
      send_term(term(Q_MIN, Q_MIN, Q_MIN, NO_INF, '0, '0, BOTH_INF, 0));
      send_term(term(Q_MIN, Q_MIN, Q_MIN, NO_INF, '0, '0, BOTH_INF, 0));
      send_term(term(Q_MIN, Q_MIN, Q_MIN, NO_INF, '0, '0, BOTH_INF, 1));
      // least sum saturates low, greatest high
      send_term(term(Q_MAX, Q_MIN, Q_MAX, NO_INF, Q_MIN, Q_MAX, NO_INF, 0));
      send_term(term(Q_MAX, Q_MIN, Q_MAX, NO_INF, Q_MIN, Q_MAX, NO_INF, 0));
      send_term(term(Q_MAX, Q_MIN, Q_MAX, NO_INF, Q_MIN, Q_MAX, NO_INF, 1));
      // both sides unbounded, later terms must not accumulate
      send_term(term(ONE, ONE, ONE, HIGH_INF, '0, '0, NO_INF, 0));
      send_term(term(-ONE, ONE, ONE, HIGH_INF, '0, '0, NO_INF, 0));
      send_term(term(3 * ONE, ONE, 2 * ONE, NO_INF, Q_MIN, Q_MAX, BOTH_INF, 1));
      // smallest coefficient above the tolerance
      send_term(term(32'sd2, Q_MAX, Q_MAX, NO_INF, '0, '0, NO_INF, 1));
      // most negative coefficient, open lower row bound
      send_term(term(Q_MIN, -ONE, ONE, NO_INF, -ONE, ONE, LOW_INF, 1));
      // open upper row bound, activity within the lower one
      send_term(term(ONE, '0, ONE, NO_INF, -ONE, '0, HIGH_INF, 1));

      // random phases over a range of tolerances, extremes included
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       value = 16'd0;
            1:       value = 16'hFFFF;
            2:       value = 16'd1;
            4:       value = 16'h8000;
            6:       value = 16'd2;
            default: value = 16'($urandom);
         endcase
         set_tolerance(value);
         steady = (phase == 2);   // one long stretch with no idling
         random_rows(PHASE_ITEMS);
         steady = 1'b0;
      end

      req_if.valid = 1'b0;
      while (rows_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hdl/rabc_pkg.sv
hdl/rabc_req_if.sv
hdl/rabc_rsp_if.sv
hdl/rabc_front.sv
hdl/rabc_queue.sv
hdl/rabc_back.sv
hdl/row_activity_bound_checker.sv
dv/row_verdict_checker.sv
dv/tb_row_activity_bound_checker.sv
